// ===== design/kct_pkg.sv =====
// shared constants, codes and the transaction token for the keyed count table
package kct_pkg;

  localparam int KEY_W        = 32;
  localparam int CNT_W        = 32;
  localparam int OP_W         = 2;
  localparam int ST_W         = 3;
  localparam int CAPACITY_DEF = 16;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;
  localparam logic [OP_W-1:0] OP_LIST   = 2'd3;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [ST_W-1:0] ST_DUPLICATE = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd4;

  localparam logic [CNT_W-1:0] CNT_MAX = 32'h7fff_ffff;
  localparam logic [CNT_W-1:0] CNT_MIN = 32'h8000_0000;

  // token walking the cell chain; for list, key is the lower bound and
  // hit/rkey/rcnt hold the best candidate so far
  typedef struct packed {
    logic             vld;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] amt;
    logic             bnd;
    logic             hit;
    logic             placed;
    logic [KEY_W-1:0] rkey;
    logic [CNT_W-1:0] rcnt;
  } kct_tok_t;

endpackage

// ===== design/kct_cell.sv =====
// one table entry cell: compares, updates or claims its entry as the token passes
module kct_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  kct_pkg::kct_tok_t tok_i,
  output kct_pkg::kct_tok_t tok_o
);

  logic                      occ_r, occ_nxt;
  logic [kct_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [kct_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  kct_pkg::kct_tok_t         tok_r, tok_nxt;
  logic [kct_pkg::CNT_W:0]   sum;
  logic [kct_pkg::CNT_W-1:0] sat;
  logic                      above_bnd;
  logic                      below_best;

  always_comb begin
    tok_nxt    = tok_i;
    key_nxt    = key_r;
    cnt_nxt    = cnt_r;
    occ_nxt    = occ_r;
    sum        = {cnt_r[kct_pkg::CNT_W-1], cnt_r} + {tok_i.amt[kct_pkg::CNT_W-1], tok_i.amt};
    sat        = sum[kct_pkg::CNT_W-1:0];
    if (sum[kct_pkg::CNT_W] != sum[kct_pkg::CNT_W-1]) begin
      sat = sum[kct_pkg::CNT_W] ? kct_pkg::CNT_MIN : kct_pkg::CNT_MAX;
    end
    above_bnd  = !tok_i.bnd || ($signed(key_r) > $signed(tok_i.key));
    below_best = !tok_i.hit || ($signed(key_r) < $signed(tok_i.rkey));
    if (tok_i.vld) begin
      if (occ_r) begin
        if (tok_i.op == kct_pkg::OP_LIST) begin
          if (above_bnd && below_best) begin
            tok_nxt.hit  = 1'b1;
            tok_nxt.rkey = key_r;
            tok_nxt.rcnt = cnt_r;
          end
        end else if (key_r == tok_i.key) begin
          tok_nxt.hit  = 1'b1;
          tok_nxt.rkey = key_r;
          tok_nxt.rcnt = cnt_r;
          if (tok_i.op == kct_pkg::OP_UPDATE) begin
            tok_nxt.rcnt = sat;
            cnt_nxt      = sat;
          end
        end
      end else if (tok_i.op == kct_pkg::OP_INSERT && !tok_i.hit && !tok_i.placed) begin
        tok_nxt.placed = 1'b1;
        tok_nxt.rkey   = tok_i.key;
        tok_nxt.rcnt   = tok_i.amt;
        key_nxt        = tok_i.key;
        cnt_nxt        = tok_i.amt;
        occ_nxt        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r     <= 1'b0;
      tok_r.vld <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    cnt_r <= cnt_nxt;
  end

  assign tok_o = tok_r;

endmodule

// ===== design/keyed_count_table_core.sv =====
// top level of the keyed count table: cell chain, control sequencer and result register
//
//  channel  direction  ports                                   handshake
//  in       input      in_opcode, in_part_key, in_amount       in_valid / in_stall
//  out      output     out_status, out_found_key, out_count,   out_valid / out_stall
//                      out_last
//
// insert, search and update: one token walks the whole cell chain, one cell per
// cycle, then the result is captured and registered.
// list makes one pass down the chain per entry, emitting the next larger key;
// an empty table answers with status empty and no pass down the chain.
// reset clears the cell occupancy and the fill count at once; no clearing pass.
// in_stall is high from acceptance until the last result is loaded into the
// output register; a stalled output holds the sequencer before the next pass.
module keyed_count_table_core #(
  parameter int CAPACITY = kct_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [kct_pkg::OP_W-1:0]        in_opcode,
  input  logic signed [kct_pkg::KEY_W-1:0] in_part_key,
  input  logic signed [kct_pkg::CNT_W-1:0] in_amount,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [kct_pkg::ST_W-1:0]        out_status,
  output logic signed [kct_pkg::KEY_W-1:0] out_found_key,
  output logic signed [kct_pkg::CNT_W-1:0] out_count,
  output logic                            out_last
);

  localparam int UW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_EMIT
  } state_t;

  state_t                    state_r;
  kct_pkg::kct_tok_t         launch_r;
  kct_pkg::kct_tok_t         chain [CAPACITY+1];
  kct_pkg::kct_tok_t         tail;
  logic [UW-1:0]             used_r;
  logic [UW-1:0]             emit_cnt_r;
  logic                      list_r;
  logic [kct_pkg::ST_W-1:0]  pend_st_r;
  logic [kct_pkg::KEY_W-1:0] pend_key_r;
  logic [kct_pkg::CNT_W-1:0] pend_cnt_r;
  logic                      pend_last_r;
  logic                      out_valid_r;
  logic [kct_pkg::ST_W-1:0]  out_status_r;
  logic [kct_pkg::KEY_W-1:0] out_key_r;
  logic [kct_pkg::CNT_W-1:0] out_cnt_r;
  logic                      out_last_r;
  logic                      in_take;
  logic                      out_free;
  logic                      tail_last;

  assign chain[0] = launch_r;
  assign tail     = chain[CAPACITY];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    kct_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i (chain[g]),
      .tok_o (chain[g+1])
    );
  end

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && (state_r == S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign tail_last = !list_r || ((emit_cnt_r + UW'(1)) == used_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      launch_r.vld <= 1'b0;
      used_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      launch_r.vld <= 1'b0;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_take) begin
            list_r     <= (in_opcode == kct_pkg::OP_LIST);
            emit_cnt_r <= '0;
            if (in_opcode == kct_pkg::OP_LIST && used_r == '0) begin
              pend_st_r   <= kct_pkg::ST_EMPTY;
              pend_key_r  <= '0;
              pend_cnt_r  <= '0;
              pend_last_r <= 1'b1;
              state_r     <= S_EMIT;
            end else begin
              launch_r.vld    <= 1'b1;
              launch_r.op     <= in_opcode;
              launch_r.key    <= $unsigned(in_part_key);
              launch_r.amt    <= $unsigned(in_amount);
              launch_r.bnd    <= 1'b0;
              launch_r.hit    <= 1'b0;
              launch_r.placed <= 1'b0;
              launch_r.rkey   <= '0;
              launch_r.rcnt   <= '0;
              state_r         <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (tail.vld) begin
            pend_last_r <= tail_last;
            pend_key_r  <= tail.rkey;
            pend_cnt_r  <= tail.rcnt;
            if (tail.op == kct_pkg::OP_INSERT) begin
              if (tail.placed) begin
                pend_st_r <= kct_pkg::ST_OK;
                used_r    <= used_r + UW'(1);
              end else if (tail.hit) begin
                pend_st_r <= kct_pkg::ST_DUPLICATE;
              end else begin
                pend_st_r  <= kct_pkg::ST_FULL;
                pend_key_r <= '0;
                pend_cnt_r <= '0;
              end
            end else if (tail.hit) begin
              pend_st_r <= kct_pkg::ST_OK;
            end else begin
              pend_st_r  <= kct_pkg::ST_NOT_FOUND;
              pend_key_r <= '0;
              pend_cnt_r <= '0;
            end
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= pend_st_r;
            out_key_r    <= pend_key_r;
            out_cnt_r    <= pend_cnt_r;
            out_last_r   <= pend_last_r;
            if (list_r && !pend_last_r) begin
              // next pass: smallest key above the one just emitted
              launch_r.vld    <= 1'b1;
              launch_r.op     <= kct_pkg::OP_LIST;
              launch_r.key    <= pend_key_r;
              launch_r.amt    <= '0;
              launch_r.bnd    <= 1'b1;
              launch_r.hit    <= 1'b0;
              launch_r.placed <= 1'b0;
              launch_r.rkey   <= '0;
              launch_r.rcnt   <= '0;
              emit_cnt_r      <= emit_cnt_r + UW'(1);
              state_r         <= S_RUN;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_found_key = $signed(out_key_r);
  assign out_count     = $signed(out_cnt_r);
  assign out_last      = out_last_r;

endmodule

// ===== bench/tb.sv =====
// self-checking bench for keyed_count_table_core: random-stall driver, monitor and table predictor
module tb;

  localparam int CAP           = kct_pkg::CAPACITY_DEF;
  localparam int RANDOM_ITEMS  = 385;
  localparam int DRAIN_CYCLES  = 400;
  localparam int HOLD_CYCLES   = 600;
  localparam int MAX_REPORTS   = 10;

  typedef struct {
    logic [kct_pkg::OP_W-1:0]         op;
    logic signed [kct_pkg::KEY_W-1:0] key;
    logic signed [kct_pkg::CNT_W-1:0] amt;
  } part_req_t;

  typedef struct {
    logic [kct_pkg::ST_W-1:0]         status;
    logic signed [kct_pkg::KEY_W-1:0] key;
    logic signed [kct_pkg::CNT_W-1:0] cnt;
    logic                             last;
  } part_resp_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [kct_pkg::OP_W-1:0]         in_opcode = kct_pkg::OP_SEARCH;
  logic signed [kct_pkg::KEY_W-1:0] in_part_key = '0;
  logic signed [kct_pkg::CNT_W-1:0] in_amount = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [kct_pkg::ST_W-1:0]         out_status;
  logic signed [kct_pkg::KEY_W-1:0] out_found_key;
  logic signed [kct_pkg::CNT_W-1:0] out_count;
  logic                             out_last;

  part_req_t                        req_q[$];
  part_req_t                        cur_req;
  part_resp_t                       pending_results[$];
  logic signed [kct_pkg::KEY_W-1:0] known_keys[$];

  logic signed [kct_pkg::KEY_W-1:0] part_keys[CAP];
  logic signed [kct_pkg::CNT_W-1:0] part_counts[CAP];
  int                               parts_used = 0;

  int accepted_items = 0;
  int total_items = 1;
  int errors = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  keyed_count_table_core u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_part_key   (in_part_key),
    .in_amount     (in_amount),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_found_key (out_found_key),
    .out_count     (out_count),
    .out_last      (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // phase 0: sender 25 / receiver 67, phase 1: swapped, phase 2: no idling
  function automatic int idle_pct(input bit receiver);
    int phase;
    phase = (accepted_items * 3) / total_items;
    if (phase == 0) return receiver ? 67 : 25;
    if (phase == 1) return receiver ? 25 : 67;
    return 0;
  endfunction

  function automatic void push_result(input logic [kct_pkg::ST_W-1:0] st,
                                      input logic signed [kct_pkg::KEY_W-1:0] k,
                                      input logic signed [kct_pkg::CNT_W-1:0] c,
                                      input logic l);
    part_resp_t e;
    e.status = st;
    e.key    = k;
    e.cnt    = c;
    e.last   = l;
    pending_results.push_back(e);
  endfunction

  task automatic apply_part_op(input part_req_t r);
    int                               hit_idx;
    int                               i;
    int                               j;
    logic signed [kct_pkg::KEY_W-1:0] sk[CAP];
    logic signed [kct_pkg::CNT_W-1:0] sc[CAP];
    logic signed [kct_pkg::KEY_W-1:0] tk;
    logic signed [kct_pkg::CNT_W-1:0] tc;
    longint                           sum;
    hit_idx = -1;
    for (i = 0; i < parts_used; i++) begin
      if (hit_idx < 0 && part_keys[i] == r.key) hit_idx = i;
    end
    case (r.op)
      kct_pkg::OP_LIST: begin
        if (parts_used == 0) begin
          push_result(kct_pkg::ST_EMPTY, '0, '0, 1'b1);
        end else begin
          for (i = 0; i < parts_used; i++) begin
            sk[i] = part_keys[i];
            sc[i] = part_counts[i];
          end
          for (i = 1; i < parts_used; i++) begin
            tk = sk[i];
            tc = sc[i];
            j = i;
            while (j > 0 && sk[j-1] > tk) begin
              sk[j] = sk[j-1];
              sc[j] = sc[j-1];
              j--;
            end
            sk[j] = tk;
            sc[j] = tc;
          end
          for (i = 0; i < parts_used; i++) begin
            push_result(kct_pkg::ST_OK, sk[i], sc[i], i == parts_used - 1);
          end
        end
      end
      kct_pkg::OP_INSERT: begin
        if (hit_idx >= 0) begin
          push_result(kct_pkg::ST_DUPLICATE, part_keys[hit_idx], part_counts[hit_idx],
                      1'b1);
        end else if (parts_used >= CAP) begin
          push_result(kct_pkg::ST_FULL, '0, '0, 1'b1);
        end else begin
          part_keys[parts_used]   = r.key;
          part_counts[parts_used] = r.amt;
          parts_used++;
          push_result(kct_pkg::ST_OK, r.key, r.amt, 1'b1);
        end
      end
      default: begin
        if (hit_idx < 0) begin
          push_result(kct_pkg::ST_NOT_FOUND, '0, '0, 1'b1);
        end else begin
          if (r.op == kct_pkg::OP_UPDATE) begin
            sum = longint'(part_counts[hit_idx]) + longint'(r.amt);
            if (sum > 64'sd2147483647) sum = 64'sd2147483647;
            else if (sum < -64'sd2147483648) sum = -64'sd2147483648;
            part_counts[hit_idx] = sum[kct_pkg::CNT_W-1:0];
          end
          push_result(kct_pkg::ST_OK, part_keys[hit_idx], part_counts[hit_idx], 1'b1);
        end
      end
    endcase
  endtask

  task automatic add_req(input logic [kct_pkg::OP_W-1:0] op,
                         input logic signed [kct_pkg::KEY_W-1:0] k,
                         input logic signed [kct_pkg::CNT_W-1:0] a);
    part_req_t r;
    r.op  = op;
    r.key = k;
    r.amt = a;
    req_q.push_back(r);
    if (op == kct_pkg::OP_INSERT) known_keys.push_back(k);
  endtask

  function automatic logic signed [kct_pkg::CNT_W-1:0] pick_amount();
    case ($urandom_range(3))
      0: return $signed($urandom_range(200)) - 100;
      1: return $urandom;
      2: return $urandom_range(1) ? kct_pkg::CNT_MAX : kct_pkg::CNT_MIN;
      default: return $urandom_range(1) ? kct_pkg::CNT_MAX - $urandom_range(1000)
                                        : kct_pkg::CNT_MIN + $urandom_range(1000);
    endcase
  endfunction

  function automatic logic signed [kct_pkg::KEY_W-1:0] pick_key();
    if ($urandom_range(3) != 0) return known_keys[$urandom_range(known_keys.size() - 1)];
    return $urandom;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_part_op(cur_req);
        accepted_items <= accepted_items + 1;
      end
      if (!in_valid || !in_stall) begin
        if (req_q.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
          cur_req = req_q.pop_front();
          in_valid    <= 1'b1;
          in_opcode   <= cur_req.op;
          in_part_key <= cur_req.key;
          in_amount   <= cur_req.amt;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    part_resp_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          if (errors < MAX_REPORTS)
            $display("unexpected result: status %0d key %0d count %0d last %0d",
                     out_status, out_found_key, out_count, out_last);
          errors++;
        end else begin
          e = pending_results.pop_front();
          if (out_status !== e.status || out_found_key !== e.key ||
              out_count !== e.cnt || out_last !== e.last) begin
            if (errors < MAX_REPORTS)
              $display({"mismatch: expected st %0d key %0d cnt %0d last %0d, ",
                        "got st %0d key %0d cnt %0d last %0d"},
                       e.status, e.key, e.cnt, e.last,
                       out_status, out_found_key, out_count, out_last);
            errors++;
          end
        end
      end
      // long hold-off while the sender keeps offering
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!hold_done && accepted_items >= (total_items * 2) / 3 + 5) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < idle_pct(1'b1));
      end
    end
  end

  initial begin
    int                               i;
    int                               sel;
    logic signed [kct_pkg::KEY_W-1:0] k;
    // directed: empty table, misses, extremes, duplicate, saturation, full table
    add_req(kct_pkg::OP_LIST, $urandom, $urandom);
    add_req(kct_pkg::OP_SEARCH, 5, 0);
    add_req(kct_pkg::OP_UPDATE, 5, 1);
    add_req(kct_pkg::OP_INSERT, kct_pkg::CNT_MIN, kct_pkg::CNT_MAX);
    add_req(kct_pkg::OP_INSERT, kct_pkg::CNT_MAX, kct_pkg::CNT_MIN);
    add_req(kct_pkg::OP_INSERT, 0, 0);
    add_req(kct_pkg::OP_INSERT, -1, -1);
    add_req(kct_pkg::OP_INSERT, 0, 77);
    add_req(kct_pkg::OP_UPDATE, kct_pkg::CNT_MIN, kct_pkg::CNT_MAX);
    add_req(kct_pkg::OP_UPDATE, kct_pkg::CNT_MAX, kct_pkg::CNT_MIN);
    add_req(kct_pkg::OP_LIST, 0, 0);
    for (i = 0; i < CAP - 4; i++) add_req(kct_pkg::OP_INSERT, $urandom, $urandom);
    add_req(kct_pkg::OP_INSERT, $urandom, $urandom);
    add_req(kct_pkg::OP_INSERT, kct_pkg::CNT_MIN, 3);
    add_req(kct_pkg::OP_LIST, $urandom, $urandom);
    // random
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      sel = $urandom_range(99);
      if (sel < 20) begin
        k = $urandom_range(1) ? pick_key() : $urandom;
        add_req(kct_pkg::OP_INSERT, k, pick_amount());
      end else if (sel < 50) begin
        add_req(kct_pkg::OP_SEARCH, pick_key(), $urandom);
      end else if (sel < 90) begin
        add_req(kct_pkg::OP_UPDATE, pick_key(), pick_amount());
      end else begin
        add_req(kct_pkg::OP_LIST, $urandom, $urandom);
      end
    end
    total_items = req_q.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (req_q.size() != 0 || in_valid) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
